// ===== rtl/core/pal_pkg.sv =====
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, widths and codes of the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

   localparam int MAX_DEPTH = 16;
   localparam int ADDR_W    = $clog2(MAX_DEPTH);
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int DATA_W    = 32;
   localparam int POS_W     = 5;
   localparam int CAP_W     = 5;
   localparam int IDX_W     = 4;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(10);

   localparam int REQ_FIELD_W = DATA_W + POS_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = CNT_W + 1 + DATA_W + IDX_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_ERASE  = 2'd1;
   localparam cmd_type CMD_DUMP   = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_RANGE = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   typedef struct packed {
      status_type status;
      logic       work;
   } check_type;

endpackage

// ===== rtl/core/pal_ram.sv =====
// ----------------------------------------------------------------------------
// pal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/pal_check.sv =====
// ----------------------------------------------------------------------------
// pal_check
// Command check: full, empty and range errors against size and capacity.
// ----------------------------------------------------------------------------
module pal_check (
   input  pal_pkg::cmd_type         cmd,
   input  logic [pal_pkg::POS_W-1:0] pos,
   input  logic [pal_pkg::CNT_W-1:0] count,
   input  logic [pal_pkg::CAP_W-1:0] capacity,
   output pal_pkg::check_type        chk
);
   import pal_pkg::*;

   logic [CNT_W-1:0] cap_eff;
   logic [CNT_W-1:0] pos_ext;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if (CNT_W'(capacity) > CNT_W'(MAX_DEPTH)) begin
         cap_eff = CNT_W'(MAX_DEPTH);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   assign pos_ext = CNT_W'(pos);

   always_comb begin
      chk.status = ST_OK;
      chk.work   = 1'b0;
      unique case (cmd)
         CMD_INSERT: begin
            if (count >= cap_eff) begin
               chk.status = ST_FULL;
            end else if (pos_ext > count) begin
               chk.status = ST_RANGE;
            end else begin
               chk.work = 1'b1;
            end
         end
         CMD_ERASE: begin
            if (count == '0) begin
               chk.status = ST_EMPTY;
            end else if (pos_ext >= count) begin
               chk.status = ST_RANGE;
            end else begin
               chk.work = 1'b1;
            end
         end
         CMD_DUMP: begin
            if (count == '0) begin
               chk.status = ST_EMPTY;
            end else begin
               chk.work = 1'b1;
            end
         end
         default: begin
            chk.status = ST_OK;
         end
      endcase
   end

endmodule

// ===== rtl/core/positional_array_list.sv =====
// ----------------------------------------------------------------------------
// positional_array_list
// Bounded ordered list with insert and erase at a position and in-order dump.
// ----------------------------------------------------------------------------
// Insert at position p into n elements: shift up in S_SHIFT_UP, one RAM move per
// cycle, then S_DRAIN and S_WRITE; insert at the end (p equal to n) goes to S_WRITE.
// Erase at position p of n elements: S_SHIFT_DN, then S_DRAIN; top entry skips both.
// Dump of n elements: one word per cycle while rsp_tready is high.
// Errors and unused codes answer through accept, then the response register.
// A held response word stalls the sequencer; reset clears size, capacity to 10.
// ----------------------------------------------------------------------------
module positional_array_list (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [pal_pkg::CAP_W-1:0]       csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pal_pkg::REQ_TDATA_W-1:0] req_tdata,  // item_value, position
   input  logic [1:0]                      req_tuser,  // command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pal_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // list_size, is_empty,
                                                       // element_value, element_index
   output logic [1:0]                      rsp_tuser,  // status
   output logic                            rsp_tlast
);
   import pal_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_DRAIN,
      S_WRITE,
      S_FINISH,
      S_DUMP
   } state_type;

   state_type          state_ff, state_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   cmd_type            cmd_ff, cmd_in;
   logic [DATA_W-1:0]  item_ff, item_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   status_type         status_ff, status_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  waddr_ff, waddr_in;
   logic               pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]   rsp_size_ff, rsp_size_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [IDX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [DATA_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [DATA_W-1:0]  ram_rd_data;

   cmd_type            req_cmd;
   logic [DATA_W-1:0]  req_item;
   logic [POS_W-1:0]   req_pos;
   check_type          chk;
   logic               out_free;
   logic               dump_last;

   assign req_cmd  = req_tuser;
   assign req_item = req_tdata[DATA_W-1:0];
   assign req_pos  = req_tdata[DATA_W+POS_W-1:DATA_W];

   pal_check u_check (
      .cmd      (req_cmd),
      .pos      (req_pos),
      .count    (count_ff),
      .capacity (cap_ff),
      .chk      (chk)
   );

   pal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dump_last  = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);

   always_comb begin
      state_in      = state_ff;
      cap_in        = csr_wr_en ? csr_wr_data : cap_ff;
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      item_in       = item_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      addr_in       = addr_ff;
      waddr_in      = waddr_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_size_in   = rsp_size_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = waddr_ff;
      ram_wr_data   = ram_rd_data;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = addr_ff;

      unique case (state_ff)
         S_IDLE: begin
            pend_in = 1'b0;
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               item_in   = req_item;
               pos_in    = req_pos;
               status_in = chk.status;
               if (!chk.work) begin
                  state_in = S_FINISH;
               end else begin
                  unique case (req_cmd)
                     CMD_INSERT: begin
                        if (CNT_W'(req_pos) == count_ff) begin
                           state_in = S_WRITE;
                        end else begin
                           addr_in  = ADDR_W'(count_ff - CNT_W'(1));
                           state_in = S_SHIFT_UP;
                        end
                     end
                     CMD_ERASE: begin
                        if ((CNT_W'(req_pos) + CNT_W'(1)) == count_ff) begin
                           count_in = count_ff - CNT_W'(1);
                           state_in = S_FINISH;
                        end else begin
                           addr_in  = ADDR_W'(req_pos) + ADDR_W'(1);
                           state_in = S_SHIFT_DN;
                        end
                     end
                     CMD_DUMP: begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        addr_in     = '0;
                        state_in    = S_DUMP;
                     end
                     default: begin
                        state_in = S_FINISH;
                     end
                  endcase
               end
            end
         end
         S_SHIFT_UP: begin
            ram_rd_en = 1'b1;
            ram_wr_en = pend_ff;
            pend_in   = 1'b1;
            waddr_in  = addr_ff + ADDR_W'(1);
            if (addr_ff == pos_ff[ADDR_W-1:0]) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff - ADDR_W'(1);
            end
         end
         S_SHIFT_DN: begin
            ram_rd_en = 1'b1;
            ram_wr_en = pend_ff;
            pend_in   = 1'b1;
            waddr_in  = addr_ff - ADDR_W'(1);
            if (dump_last) begin
               state_in = S_DRAIN;
            end else begin
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_DRAIN: begin
            ram_wr_en = 1'b1;
            pend_in   = 1'b0;
            if (cmd_ff == CMD_INSERT) begin
               state_in = S_WRITE;
            end else begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_FINISH;
            end
         end
         S_WRITE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[ADDR_W-1:0];
            ram_wr_data = item_ff;
            count_in    = count_ff + CNT_W'(1);
            state_in    = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_size_in   = count_ff;
               rsp_empty_in  = (count_ff == '0);
               rsp_value_in  = '0;
               rsp_index_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_size_in   = count_ff;
               rsp_empty_in  = 1'b0;
               rsp_value_in  = ram_rd_data;
               rsp_index_in  = IDX_W'(addr_ff);
               rsp_last_in   = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = addr_ff + ADDR_W'(1);
                  addr_in     = addr_ff + ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      item_ff       <= item_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      addr_ff       <= addr_in;
      waddr_ff      <= waddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_FIELD_W){1'b0}},
                        rsp_index_ff, rsp_value_ff, rsp_empty_ff, rsp_size_ff};

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_DEPTH))
      else $error("list size beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == S_IDLE || $past(state_ff) == S_DRAIN ||
          $past(state_ff) == S_WRITE))
      else $error("list size changed outside an update step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_empty_ff == (rsp_size_ff == '0)))
      else $error("empty flag disagrees with size");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> rsp_last_ff)
      else $error("error word not marked last");

endmodule
